// ===== rtl/hysteresis_thermostat_lockout_assert.svh =====
// ----------------------------------------------------------------------------
// Thermostat lockout assertion macros
// Shared concurrent assertion forms used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef HYSTERESIS_THERMOSTAT_LOCKOUT_ASSERT_SVH
`define HYSTERESIS_THERMOSTAT_LOCKOUT_ASSERT_SVH

// Check expr at every edge while rst is low.
`define THL_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that cond implies expr in the same cycle.
`define THL_ASSERT_IMPL(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Check that cond implies expr in the next cycle.
`define THL_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== rtl/thl_pkg.sv =====
// ----------------------------------------------------------------------------
// Thermostat lockout package
// Register codes, mode codes, configuration struct and shared constants.
// ----------------------------------------------------------------------------
package thl_pkg;

   localparam int ELAPSED_BITS_DEF = 16;
   localparam int TEMP_BITS        = 16;
   localparam int BAND_BITS        = 15;
   localparam int MIN_SEC_BITS     = 16;
   localparam int POWER_BITS       = 7;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 16;
   localparam int RSP_DATA_BITS    = 16;

   localparam logic [POWER_BITS-1:0] FULL_POWER = 7'd100;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_SETPOINT   = 3'd0,
      REG_BAND       = 3'd1,
      REG_DIRECTION  = 3'd2,
      REG_KIND       = 3'd3,
      REG_MIN_SWITCH = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      DIR_HEAT = 2'd0,
      DIR_COOL = 2'd1,
      DIR_IDLE = 2'd2
   } direction_type;

   typedef enum logic [1:0] {
      KIND_ONOFF      = 2'd0,
      KIND_COMPRESSOR = 2'd1,
      KIND_PID        = 2'd2
   } kind_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   typedef struct packed {
      logic signed [TEMP_BITS-1:0] setpoint;
      logic [BAND_BITS-1:0]        band;
      logic [1:0]                  direction;
      logic [1:0]                  control_kind;
      logic [MIN_SEC_BITS-1:0]     min_switch_seconds;
   } cfg_type;

   typedef struct packed {
      logic                        valid;
      logic                        op;
      logic signed [TEMP_BITS-1:0] temperature;
   } item_type;

endpackage

// ===== rtl/thl_csr.sv =====
// ----------------------------------------------------------------------------
// Thermostat lockout configuration registers
// Write-only register file; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module thl_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [thl_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [thl_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output thl_pkg::cfg_type                     cfg
);
   import thl_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_SETPOINT:   cfg_in.setpoint           = csr_wdata;
            REG_BAND:       cfg_in.band               = csr_wdata[BAND_BITS-1:0];
            REG_DIRECTION:  cfg_in.direction          = csr_wdata[1:0];
            REG_KIND:       cfg_in.control_kind       = csr_wdata[1:0];
            REG_MIN_SWITCH: cfg_in.min_switch_seconds = csr_wdata[MIN_SEC_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint           <= '0;
         cfg_ff.band               <= '0;
         cfg_ff.direction          <= DIR_IDLE;
         cfg_ff.control_kind       <= KIND_ONOFF;
         cfg_ff.min_switch_seconds <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/thl_in_reg.sv =====
// ----------------------------------------------------------------------------
// Thermostat lockout input register
// Capture one word per cycle; hold it while the result side is stalled.
// ----------------------------------------------------------------------------
module thl_in_reg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [thl_pkg::TEMP_BITS-1:0]        req_tdata,
   input  logic                                 req_tuser,
   input  logic                                 advance,
   output thl_pkg::item_type                    item
);
   import thl_pkg::*;

   logic                        valid_ff, valid_in;
   logic                        op_ff, op_in;
   logic signed [TEMP_BITS-1:0] temp_ff, temp_in;
   logic                        take;

   // Free slot, or the held word moves on this cycle.
   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      op_in    = op_ff;
      temp_in  = temp_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end
      if (take) begin
         op_in   = req_tuser;
         temp_in = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      op_ff   <= op_in;
      temp_ff <= temp_in;
   end

   assign item.valid       = valid_ff;
   assign item.op          = op_ff;
   assign item.temperature = temp_ff;

endmodule

// ===== rtl/thl_core.sv =====
// ----------------------------------------------------------------------------
// Thermostat lockout decision core
// Hysteresis compare, lockout check, state update and result register.
// ----------------------------------------------------------------------------
module thl_core #(
   parameter int ELAPSED_BITS = thl_pkg::ELAPSED_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  thl_pkg::cfg_type                     cfg,
   input  thl_pkg::item_type                    item,
   input  logic                                 advance,
   output logic                                 rsp_tvalid,
   output logic [thl_pkg::RSP_DATA_BITS-1:0]    rsp_tdata
);
   import thl_pkg::*;

   localparam int CMP_BITS  = (ELAPSED_BITS > MIN_SEC_BITS) ? ELAPSED_BITS : MIN_SEC_BITS;
   localparam int TRIP_BITS = TEMP_BITS + 2;
   localparam int PAD_BITS  = RSP_DATA_BITS - POWER_BITS - 2;

   logic                     power_ff, power_in;
   logic [ELAPSED_BITS-1:0]  count_ff, count_in;
   logic                     out_valid_ff, out_valid_in;
   logic                     switched_ff, switched_in;
   logic                     held_ff, held_in;

   logic signed [TRIP_BITS-1:0] temp_x, setpoint_x, band_x, on_trip;
   logic active, heat, want, allow, fire;

   always_comb begin
      temp_x     = TRIP_BITS'(item.temperature);
      setpoint_x = TRIP_BITS'(cfg.setpoint);
      band_x     = $signed({3'b000, cfg.band});
      heat       = (cfg.direction == DIR_HEAT);
      on_trip    = heat ? (setpoint_x - band_x) : (setpoint_x + band_x);

      active = ((cfg.control_kind == KIND_ONOFF) || (cfg.control_kind == KIND_COMPRESSOR))
             && ((cfg.direction == DIR_HEAT) || (cfg.direction == DIR_COOL));

      if (heat) begin
         want = (!power_ff && (temp_x < on_trip)) || (power_ff && (temp_x > setpoint_x));
      end else begin
         want = (!power_ff && (temp_x > on_trip)) || (power_ff && (temp_x < setpoint_x));
      end

      // Saturated counter stands for unlimited time.
      allow = (cfg.control_kind != KIND_COMPRESSOR) || (&count_ff)
            || (CMP_BITS'(count_ff) >= CMP_BITS'(cfg.min_switch_seconds));

      fire = (item.op == OP_SAMPLE) && active && want;
   end

   always_comb begin
      power_in     = power_ff;
      count_in     = count_ff;
      switched_in  = switched_ff;
      held_in      = held_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = item.valid;
         if (item.valid) begin
            switched_in = fire && allow;
            held_in     = fire && !allow;
            if (item.op == OP_TICK) begin
               if (!(&count_ff)) begin
                  count_in = count_ff + 1'b1;
               end
            end else if (fire && allow) begin
               power_in = !power_ff;
               count_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff     <= 1'b0;
         count_ff     <= '1;
         out_valid_ff <= 1'b0;
      end else begin
         power_ff     <= power_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      switched_ff <= switched_in;
      held_ff     <= held_in;
   end

   // Power reflects state after the item; it only moves together with the result.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PAD_BITS{1'b0}}, held_ff, switched_ff,
                        (power_ff ? FULL_POWER : {POWER_BITS{1'b0}})};

endmodule

// ===== rtl/hysteresis_thermostat_lockout.sv =====
// ----------------------------------------------------------------------------
// Hysteresis thermostat with compressor lockout
// On/off channel controller for one node, one result word per input word.
// ----------------------------------------------------------------------------
// Use:
//   req_*  carries input words: a temperature sample (req_tuser low) or a
//          one-second tick (req_tuser high). Every word yields exactly one
//          result word on rsp_*.
//   rsp_*  carries power (0 or 100) plus switched and lockout-held flags.
//   csr_*  writes setpoint, band, direction, control kind and minimum
//          switch seconds; write only while no word is in flight.
// An accepted request word passes through the input register and then the
// result register. Throughput is one word per cycle while rsp_tready does not
// stall the result side, set by the compare and state update in the decision
// core, which handle each word as it moves into the result register.
// A stall on rsp_tready holds the result word and the input register; the
// request side stays open until that register is occupied, so one more word
// is taken during a stall before req_tready drops.
// Reset clears both valid flags, turns the output off, saturates the
// elapsed counter and loads the register defaults (direction idle).
// ----------------------------------------------------------------------------
module hysteresis_thermostat_lockout #(
   parameter int ELAPSED_BITS = thl_pkg::ELAPSED_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [thl_pkg::TEMP_BITS-1:0]        req_tdata,   // [15:0] temperature
   input  logic                                 req_tuser,   // [0] op (1 tick)
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [thl_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,   // [6:0] power_percent,
                                                             // [7] switched,
                                                             // [8] held_by_lockout
   // configuration writes
   input  logic                                 csr_we,
   input  logic [thl_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [thl_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import thl_pkg::*;

   cfg_type  cfg;
   item_type item;
   logic     advance;

   // Advance the pipe whenever the result register is empty or being taken.
   assign advance = !rsp_tvalid || rsp_tready;

   thl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   thl_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item       (item)
   );

   thl_core #(
      .ELAPSED_BITS (ELAPSED_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item       (item),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/thl_checker.sv =====
// ----------------------------------------------------------------------------
// Thermostat lockout port checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "hysteresis_thermostat_lockout_assert.svh"

module thl_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [thl_pkg::RSP_DATA_BITS-1:0]    rsp_tdata
);
   import thl_pkg::*;

   // Drive is full or nothing.
   `THL_ASSERT_IMPL(a_power_level, clock, reset, rsp_tvalid, (rsp_tdata[POWER_BITS-1:0] == FULL_POWER) || (rsp_tdata[POWER_BITS-1:0] == '0), "power not 0 or 100")
   // A word either switches or is held, never both.
   `THL_ASSERT_IMPL(a_flags_excl, clock, reset, rsp_tvalid, !(rsp_tdata[POWER_BITS] && rsp_tdata[POWER_BITS+1]), "switched and held together")
   // No result appears right after reset without a request.
   `THL_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid && req_tready, "result valid after reset")
   // Stalled result holds.
   `THL_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   // Input side stays open while the result side drains.
   `THL_ASSERT_IMPL(a_ready_open, clock, reset, rsp_tready || !rsp_tvalid, req_tready, "request blocked while result drains")

endmodule

bind hysteresis_thermostat_lockout thl_checker u_thl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== bench/hysteresis_thermostat_lockout_test.sv =====
// ----------------------------------------------------------------------------
// Thermostat lockout block test
// Sends temperature and tick words into the thermostat, predicts the drive
// word for each accepted request, and compares every result field by field.
// A directed part covers trip points, the lockout and the inert modes; random
// traffic then runs under several settings with idling on either side.
// ----------------------------------------------------------------------------
module hysteresis_thermostat_lockout_test;
   timeunit 1ns;
   timeprecision 1ps;

   import thl_pkg::*;

   localparam int ELAPSED_BITS      = ELAPSED_BITS_DEF;
   localparam int LONG_HOLD_CYCLES  = 48;    // receiver hold-off for the fill test
   localparam int WATCHDOG_LIMIT    = 4000;  // cycles with no word moving on either side
   localparam int SETTLE_CYCLES     = 8;     // margin after the final drain
   localparam int BURST_WORDS       = 56;
   localparam int SETTINGS_PER_MODE = 4;
   localparam int MAX_REPORTS       = 10;

   // Register codes that the package leaves unnamed; the block treats them as inert.
   localparam logic [1:0] DIR_UNUSED  = 2'd3;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [ELAPSED_BITS-1:0] ELAPSED_FULL = '1;

   typedef struct packed {
      logic [POWER_BITS-1:0] power;
      logic                  switched;
      logic                  held;
   } drive_word_type;

   // Block ports, all at a known value from time zero.
   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [TEMP_BITS-1:0]      req_tdata  = '0;
   logic                      req_tuser  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_we     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;

   // Predictor copy of the registers, at their reset values.
   logic signed [TEMP_BITS-1:0] cfg_setpoint = '0;
   logic [BAND_BITS-1:0]        cfg_band     = '0;
   logic [1:0]                  cfg_dir      = DIR_IDLE;
   logic [1:0]                  cfg_kind     = KIND_ONOFF;
   logic [MIN_SEC_BITS-1:0]     cfg_min_sec  = '0;

   // Predictor copy of the channel state: output off, elapsed counter saturated.
   logic                    power_on = 1'b0;
   logic [ELAPSED_BITS-1:0] elapsed  = ELAPSED_FULL;

   drive_word_type predicted_drive[$];
   int             mismatches = 0;

   // Idling knobs, percent of cycles; written only by the stimulus thread.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int holds_asked   = 0;

   hysteresis_thermostat_lockout u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [15:0] temperature
      .req_tuser  (req_tuser),   // [0] op (1 tick)
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [6:0] power_percent, [7] switched, [8] held_by_lockout
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // A wanted switch goes through unless the compressor is still locked out.
   // A saturated counter stands for unlimited time.
   function automatic logic lockout_clear();
      return (cfg_kind != KIND_COMPRESSOR) || (elapsed == ELAPSED_FULL) ||
             (elapsed >= cfg_min_sec);
   endfunction

   // Advance the channel by one request word and return its drive word.
   function automatic drive_word_type step_thermostat(logic op,
                                                      logic signed [TEMP_BITS-1:0] temp);
      drive_word_type r;
      int             t;
      int             sp;
      int             on_trip;
      logic           want;
      r    = '0;
      want = 1'b0;
      if (op == OP_TICK) begin
         if (elapsed != ELAPSED_FULL) elapsed = elapsed + 1'b1;
      end else if ((cfg_kind == KIND_ONOFF || cfg_kind == KIND_COMPRESSOR) &&
                   (cfg_dir == DIR_HEAT || cfg_dir == DIR_COOL)) begin
         // Trip points are taken at full integer width, no wrap.
         t       = temp;
         sp      = cfg_setpoint;
         on_trip = (cfg_dir == DIR_HEAT) ? sp - int'(cfg_band) : sp + int'(cfg_band);
         if (cfg_dir == DIR_HEAT) want = power_on ? (t > sp) : (t < on_trip);
         else                     want = power_on ? (t < sp) : (t > on_trip);
         if (want) begin
            if (lockout_clear()) begin
               power_on   = !power_on;
               elapsed    = '0;
               r.switched = 1'b1;
            end else begin
               r.held = 1'b1;
            end
         end
      end
      r.power = power_on ? FULL_POWER : '0;
      return r;
   endfunction

   // Track register writes and accepted request words at each edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               REG_SETPOINT:   cfg_setpoint = csr_wdata;
               REG_BAND:       cfg_band     = csr_wdata[BAND_BITS-1:0];
               REG_DIRECTION:  cfg_dir      = csr_wdata[1:0];
               REG_KIND:       cfg_kind     = csr_wdata[1:0];
               REG_MIN_SWITCH: cfg_min_sec  = csr_wdata[MIN_SEC_BITS-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predicted_drive.push_back(step_thermostat(req_tuser, req_tdata));
      end
   end

   // ---------------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------------

   task automatic note_mismatch(string field, int want, int got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch in %s: expected %0d, got %0d", field, want, got);
   endtask

   always @(posedge clock) begin
      drive_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (predicted_drive.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result word with nothing pending: %h", rsp_tdata);
         end else begin
            want = predicted_drive.pop_front();
            if (rsp_tdata[6:0] !== want.power)  note_mismatch("power", want.power, rsp_tdata[6:0]);
            if (rsp_tdata[7] !== want.switched) note_mismatch("switched", want.switched, rsp_tdata[7]);
            if (rsp_tdata[8] !== want.held)     note_mismatch("held", want.held, rsp_tdata[8]);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off on request.
   // ---------------------------------------------------------------------------
   int hold_left     = 0;
   int holds_granted = 0;

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_granted != holds_asked) begin
         rsp_tready    <= 1'b0;
         hold_left     <= LONG_HOLD_CYCLES - 1;
         holds_granted <= holds_granted + 1;
      end else begin
         rsp_tready <= (int'($urandom_range(99)) >= rsp_stall_pct);
      end
   end

   // Watchdog: give up when no word moves on either side for too long.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word accepted for %0d cycles", quiet_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers; every call starts and ends at a rising edge.
   // ---------------------------------------------------------------------------

   // Offer one request word, after a random gap, and hold it until accepted.
   // Leave tvalid high so back-to-back words need no second assignment.
   task automatic send_word(logic op, logic [TEMP_BITS-1:0] temp);
      int gap;
      gap = 0;
      while (gap < 30 && int'($urandom_range(99)) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= temp;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop tvalid and wait for every pending result word.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (predicted_drive.size() != 0);
   endtask

   // Write all five registers, only once the block has gone idle.
   task automatic write_settings(logic signed [TEMP_BITS-1:0] sp, logic [BAND_BITS-1:0] bd,
                                 logic [1:0] dir, logic [1:0] kind,
                                 logic [MIN_SEC_BITS-1:0] min_sec);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= REG_SETPOINT;
      csr_wdata <= sp;
      @(posedge clock);
      csr_index <= REG_BAND;
      csr_wdata <= CSR_DATA_BITS'(bd);
      @(posedge clock);
      csr_index <= REG_DIRECTION;
      csr_wdata <= CSR_DATA_BITS'(dir);
      @(posedge clock);
      csr_index <= REG_KIND;
      csr_wdata <= CSR_DATA_BITS'(kind);
      @(posedge clock);
      csr_index <= REG_MIN_SWITCH;
      csr_wdata <= min_sec;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------------------

   // Reset leaves the channel idle: nothing switches, ticks keep the counter saturated.
   task automatic test_reset_defaults();
      send_word(OP_SAMPLE, 16'h8000);
      send_word(OP_SAMPLE, 16'h7FFF);
      send_word(OP_TICK, 16'hFFFF);
   endtask

   // The saturated counter from reset satisfies even the longest lockout;
   // after a switch, a wanted switch is held until enough ticks pass.
   task automatic test_compressor_lockout();
      write_settings(16'sd0, 15'd0, DIR_HEAT, KIND_COMPRESSOR, 16'hFFFF);
      send_word(OP_SAMPLE, 16'hFFFF);   // -1 below trip: switch on
      send_word(OP_SAMPLE, 16'd1);      // wants off, locked out
      repeat (3) send_word(OP_TICK, 16'h0000);
      write_settings(16'sd0, 15'd0, DIR_HEAT, KIND_COMPRESSOR, 16'd3);
      send_word(OP_SAMPLE, 16'd1);      // three seconds elapsed: switch off
   endtask

   // Heat: on strictly below setpoint - band, off strictly above setpoint.
   task automatic test_heat_onoff();
      write_settings(16'sd0, 15'd10, DIR_HEAT, KIND_ONOFF, 16'd0);
      send_word(OP_SAMPLE, 16'hFFF6);   // -10, at the trip point: stay off
      send_word(OP_SAMPLE, 16'hFFF5);   // -11: on
      send_word(OP_SAMPLE, 16'd0);      // at setpoint: stay on
      send_word(OP_SAMPLE, 16'd1);      // above: off
   endtask

   // Cool mirrors heat around setpoint + band.
   task automatic test_cool_onoff();
      write_settings(16'sd100, 15'd5, DIR_COOL, KIND_ONOFF, 16'd0);
      send_word(OP_SAMPLE, 16'd105);
      send_word(OP_SAMPLE, 16'd106);
      send_word(OP_SAMPLE, 16'd100);
      send_word(OP_SAMPLE, 16'd99);
   endtask

   // Trip points beyond the 16-bit range must not wrap.
   task automatic test_trip_extremes();
      write_settings(16'sh7FFF, 15'h7FFF, DIR_HEAT, KIND_ONOFF, 16'd0);
      send_word(OP_SAMPLE, 16'hFFFF);   // trip at 0: on
      send_word(OP_SAMPLE, 16'h7FFF);   // equal to setpoint: stay on
      write_settings(-16'sh8000, 15'h7FFF, DIR_HEAT, KIND_ONOFF, 16'd0);
      send_word(OP_SAMPLE, 16'h7FFF);   // above setpoint: off
      send_word(OP_SAMPLE, 16'h8000);   // trip far below range: stay off
   endtask

   // Unused and idle directions, pid kind and unused kind never switch.
   task automatic test_inert_modes();
      write_settings(16'sd0, 15'd0, DIR_UNUSED, KIND_ONOFF, 16'd0);
      send_word(OP_SAMPLE, 16'hFFFF);
      write_settings(16'sd0, 15'd0, DIR_HEAT, KIND_PID, 16'd0);
      send_word(OP_SAMPLE, 16'hFFFF);
      write_settings(16'sd0, 15'd0, DIR_HEAT, KIND_UNUSED, 16'd0);
      send_word(OP_SAMPLE, 16'hFFFF);
      write_settings(16'sd0, 15'd0, DIR_IDLE, KIND_ONOFF, 16'd0);
      send_word(OP_SAMPLE, 16'd5);
   endtask

   // ---------------------------------------------------------------------------
   // Random traffic
   // ---------------------------------------------------------------------------

   // Pick a setting, leaning to active modes and small lockout times.
   task automatic random_settings();
      logic signed [TEMP_BITS-1:0] sp;
      logic [BAND_BITS-1:0]        bd;
      logic [1:0]                  dir;
      logic [1:0]                  kind;
      logic [MIN_SEC_BITS-1:0]     min_sec;
      int                          pick;
      pick = $urandom_range(99);
      if (pick < 10)      sp = -16'sh8000;
      else if (pick < 20) sp = 16'sh7FFF;
      else if (pick < 70) sp = TEMP_BITS'(int'($urandom_range(400)) - 200);
      else                sp = TEMP_BITS'($urandom);
      pick = $urandom_range(99);
      if (pick < 10)      bd = '0;
      else if (pick < 20) bd = '1;
      else if (pick < 80) bd = BAND_BITS'($urandom_range(20));
      else                bd = BAND_BITS'($urandom);
      pick = $urandom_range(99);
      if (pick < 40)      dir = DIR_HEAT;
      else if (pick < 80) dir = DIR_COOL;
      else if (pick < 90) dir = DIR_IDLE;
      else                dir = DIR_UNUSED;
      pick = $urandom_range(99);
      if (pick < 45)      kind = KIND_ONOFF;
      else if (pick < 80) kind = KIND_COMPRESSOR;
      else if (pick < 90) kind = KIND_PID;
      else                kind = KIND_UNUSED;
      pick = $urandom_range(99);
      if (pick < 5)       min_sec = '1;
      else if (pick < 10) min_sec = MIN_SEC_BITS'($urandom);
      else                min_sec = MIN_SEC_BITS'($urandom_range(6));
      write_settings(sp, bd, dir, kind, min_sec);
   endtask

   // Mostly samples close to the trip points, with ticks to run down the lockout.
   task automatic random_burst(int count);
      int pick;
      int base;
      int t;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            send_word(OP_TICK, TEMP_BITS'($urandom));
         end else begin
            if (pick < 85) begin
               case ($urandom_range(2))
                  0:       base = cfg_setpoint;
                  1:       base = int'(cfg_setpoint) - int'(cfg_band);
                  default: base = int'(cfg_setpoint) + int'(cfg_band);
               endcase
               t = base + int'($urandom_range(8)) - 4;
               if (t > 32767)  t = 32767;
               if (t < -32768) t = -32768;
            end else begin
               t = int'($urandom_range(65535)) - 32768;
            end
            send_word(OP_SAMPLE, TEMP_BITS'(t));
         end
      end
   endtask

   // Hold the receiver off while words keep coming so the block fills and
   // stalls its input, then pause the sender until everything has drained.
   task automatic test_backpressure();
      write_settings(16'sd0, 15'd3, DIR_HEAT, KIND_ONOFF, 16'd0);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      holds_asked++;
      random_burst(20);
      drain_results();
   endtask

   // Run the random traffic under each idling mode.
   task automatic test_random_traffic();
      int send_modes[4] = '{0, 71, 0, 16};
      int stall_modes[4] = '{0, 0, 71, 16};
      for (int m = 0; m < 4; m++) begin
         send_idle_pct = send_modes[m];
         rsp_stall_pct = stall_modes[m];
         for (int s = 0; s < SETTINGS_PER_MODE; s++) begin
            random_settings();
            random_burst(BURST_WORDS);
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_compressor_lockout();
      test_heat_onoff();
      test_cool_onoff();
      test_trip_extremes();
      test_inert_modes();
      test_backpressure();
      test_random_traffic();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0 && predicted_drive.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
